// ----- hdl/mrcm_pkg.sv -----
// Shared constants, codes and the row token type of the ring count map.
package mrcm_pkg;

    localparam int GRID_W_DEF      = 64;
    localparam int GRID_H_DEF      = 64;
    localparam int REACH_LIMIT_DEF = 15;

    localparam int FUNC_W  = 2;
    localparam int COORD_W = 6;
    localparam int REACH_W = 4;
    localparam int CFG_W   = 7;
    localparam int CFG_AW  = 1;
    localparam int COUNT_W = 8;
    localparam int ROW_W   = 8;   // row address carried by a token, grids up to 256 rows
    localparam int SPAN_W  = 7;
    localparam int POS_W   = 9;   // column and size compares, up to 256
    localparam int SWEEP_W = 7;   // up to 2*63 + 1 rows per ring

    localparam logic [CFG_W-1:0] MAP_SIZE_RST = 7'd64;

    localparam logic [CFG_AW-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MAP_HEIGHT = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD   = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_ADD = 2'd1,
        OP_CLR = 2'd2,
        OP_RD  = 2'd3
    } op_t;

    // One grid row of work, passed from cell to cell along the chain.
    typedef struct packed {
        op_t                op;
        logic               ret;       // closes an item: tail emits carry as its result
        logic [ROW_W-1:0]   row;
        logic [COORD_W-1:0] cx;
        logic               inc_ok;
        logic [SPAN_W-1:0]  inc_span;
        logic               dec_ok;
        logic [SPAN_W-1:0]  dec_span;
        logic [COUNT_W-1:0] carry;
    } token_t;

endpackage

// ----- hdl/mrcm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module mrcm_ram
    import mrcm_pkg::*;
#(
    parameter int WIDTH = COUNT_W,
    parameter int DEPTH = GRID_H_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/mrcm_cell.sv -----
// One grid column: its counter RAM and the per-row update, one chain stage.
module mrcm_cell
    import mrcm_pkg::*;
#(
    parameter int GRID_H = GRID_H_DEF,
    parameter int CELL_X = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [POS_W-1:0] used_w,
    input  token_t           tok_in,
    output token_t           tok_out
);

    localparam int RA_W = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam logic [POS_W-1:0] X = POS_W'(CELL_X);

    token_t             tok_reg;
    logic [COUNT_W-1:0] rd_data;
    logic [COUNT_W-1:0] wr_data;
    logic               we;
    logic               col_ok;
    logic               up;
    logic               dn;
    logic [POS_W-1:0]   cx_w;
    logic [POS_W-1:0]   dx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_comb
    begin
        cx_w   = POS_W'(tok_reg.cx);
        dx     = (cx_w > X) ? (cx_w - X) : (X - cx_w);
        col_ok = X < used_w;
        up     = col_ok && tok_reg.inc_ok && (dx <= POS_W'(tok_reg.inc_span));
        dn     = col_ok && tok_reg.dec_ok && (dx <= POS_W'(tok_reg.dec_span));
        we     = 1'b0;
        wr_data = rd_data + COUNT_W'(up) - COUNT_W'(dn);
        case (tok_reg.op)
            OP_ADD:
            begin
                we = up ^ dn;
            end
            OP_CLR:
            begin
                we      = 1'b1;
                wr_data = '0;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase

        tok_out = tok_reg;
        if (tok_reg.op == OP_RD && cx_w == X)
        begin
            tok_out.carry = rd_data;
        end
    end

    // read address comes from the incoming token so data lines up with tok_reg
    mrcm_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (GRID_H)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (tok_reg.row[RA_W-1:0]),
        .wdata (wr_data),
        .raddr (tok_in.row[RA_W-1:0]),
        .rdata (rd_data)
    );

endmodule

// ----- hdl/mrcm_seq.sv -----
// Item sequencer: turns each input item into row tokens at the head of the chain.
module mrcm_seq
    import mrcm_pkg::*;
#(
    parameter int GRID_H      = GRID_H_DEF,
    parameter int REACH_LIMIT = REACH_LIMIT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  logic [REACH_W-1:0] min_reach,
    input  logic [REACH_W-1:0] max_reach,
    input  logic [POS_W-1:0]   used_w,
    input  logic [POS_W-1:0]   used_h,
    input  logic               credit_full,
    output logic               acc,
    output token_t             head
);

    localparam logic [COORD_W-1:0] RANGE_C    = COORD_W'(REACH_LIMIT);
    localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'(2 * REACH_LIMIT);
    localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(GRID_H - 1);

    typedef enum logic [4:0] {
        ST_INIT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_ADD  = 5'b00100,
        ST_CLR  = 5'b01000,
        ST_TAIL = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [SWEEP_W-1:0] k_reg, k_next;
    logic [ROW_W-1:0]   rowc_reg, rowc_next;
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [COORD_W-1:0] rmax_reg, rmax_next;
    logic [COORD_W-1:0] rmin_reg, rmin_next;
    logic               tail_ret_reg, tail_ret_next;
    token_t             head_reg, head_next;

    logic [COORD_W-1:0] rmax_c;
    logic [COORD_W-1:0] rmin_c;
    logic               rd_hit;
    logic signed [7:0]  off;
    logic [COORD_W-1:0] dy;
    logic signed [9:0]  ysum;
    logic               row_ok;

    assign in_stall = (state_reg != ST_IDLE) || credit_full;
    assign acc      = in_valid && !in_stall;
    assign head     = head_reg;

    always_comb
    begin
        rmax_c = ({2'b0, max_reach} > RANGE_C) ? RANGE_C : {2'b0, max_reach};
        rmin_c = ({2'b0, min_reach} > RANGE_C) ? RANGE_C : {2'b0, min_reach};
        rd_hit = (POS_W'(col) < used_w) && (POS_W'(row) < used_h);

        // ring row offset from the centre runs -REACH_LIMIT .. +REACH_LIMIT
        off    = $signed({1'b0, k_reg}) - $signed({2'b0, RANGE_C});
        dy     = COORD_W'(off[7] ? -off : off);
        ysum   = $signed({4'b0, cy_reg}) + $signed({{2{off[7]}}, off});
        row_ok = !ysum[9] && (ysum[8:0] < used_h);
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        rowc_next     = rowc_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        rmax_next     = rmax_reg;
        rmin_next     = rmin_reg;
        tail_ret_next = tail_ret_reg;
        head_next     = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                head_next.op  = OP_CLR;
                head_next.row = rowc_reg;
                if (rowc_reg == ROW_LAST)
                begin
                    state_next    = ST_TAIL;
                    tail_ret_next = 1'b0;
                    rowc_next     = '0;
                end
                else
                begin
                    rowc_next = rowc_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (func_t'(func))
                        FN_ADD:
                        begin
                            state_next = ST_ADD;
                            k_next     = '0;
                            cx_next    = col;
                            cy_next    = row;
                            rmax_next  = rmax_c;
                            rmin_next  = rmin_c;
                        end
                        FN_READ:
                        begin
                            head_next.ret = 1'b1;
                            if (rd_hit)
                            begin
                                head_next.op  = OP_RD;
                                head_next.row = ROW_W'(row);
                                head_next.cx  = col;
                            end
                        end
                        FN_CLEAR:
                        begin
                            state_next = ST_CLR;
                            rowc_next  = '0;
                        end
                        default:
                        begin
                            head_next.ret = 1'b1;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                if (row_ok)
                begin
                    head_next.op       = OP_ADD;
                    head_next.row      = ysum[ROW_W-1:0];
                    head_next.cx       = cx_reg;
                    head_next.inc_ok   = dy <= rmax_reg;
                    head_next.inc_span = SPAN_W'(rmax_reg - dy);
                    // subtraction covers distances up to min_reach - 1
                    head_next.dec_ok   = dy < rmin_reg;
                    head_next.dec_span = SPAN_W'(rmin_reg - dy - 1'b1);
                end
                if (k_reg == SWEEP_LAST)
                begin
                    state_next    = ST_TAIL;
                    tail_ret_next = 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_CLR:
            begin
                head_next.op  = OP_CLR;
                head_next.row = rowc_reg;
                if (rowc_reg == ROW_LAST)
                begin
                    state_next    = ST_TAIL;
                    tail_ret_next = 1'b1;
                    rowc_next     = '0;
                end
                else
                begin
                    rowc_next = rowc_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                // idle token: also keeps a gap before the next item touches the same row
                head_next.ret = tail_ret_reg;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            k_reg        <= '0;
            rowc_reg     <= '0;
            tail_ret_reg <= 1'b0;
            head_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            rowc_reg     <= rowc_next;
            tail_ret_reg <= tail_ret_next;
            head_reg     <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        rmax_reg <= rmax_next;
        rmin_reg <= rmin_next;
    end

endmodule

// ----- hdl/manhattan_ring_count_map_unit.sv -----
// Top level of the Manhattan ring count map: config, sequencer, cell chain, result stage.
//
// Keeps a GRID_H x GRID_W grid of 8-bit wrapping counters, one cell per column,
// each cell holding its column in a small RAM. Items arrive on in_valid/in_stall
// and results leave on out_valid/out_stall; a transfer happens when valid is high
// and stall is low. Every item gives exactly one result (cell_count).
// Config: cfg_we with cfg_addr 0 writes map_width, 1 writes map_height; write
// only while the block is idle.
// The sequencer issues one grid row per cycle down the chain of cells; each cell
// reads and rewrites its RAM entry for that row and passes the row on.
// An add sweeps the ring rows from -REACH_LIMIT to +REACH_LIMIT around its centre and a
// clear sweeps every row, each followed by an idle tail token, with in_stall high; a read
// issues a single row token. A result leaves once the item's last row has passed every cell.
// Up to two results may be held at the output; with both slots owed, in_stall
// rises until out_stall lets one go. A stalled result holds its value.
// Reset: after rst_n is released the grid is cleared one row per cycle, with in_stall
// high until the clearing pass and its tail token are done; config writes are taken meanwhile.
module manhattan_ring_count_map_unit
    import mrcm_pkg::*;
#(
    parameter int GRID_W      = GRID_W_DEF,
    parameter int GRID_H      = GRID_H_DEF,
    parameter int REACH_LIMIT = REACH_LIMIT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  logic [REACH_W-1:0] min_reach,
    input  logic [REACH_W-1:0] max_reach,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] cell_count
);

    logic [CFG_W-1:0]   map_width_reg;
    logic [CFG_W-1:0]   map_height_reg;
    logic [POS_W-1:0]   used_w;
    logic [POS_W-1:0]   used_h;
    logic [1:0]         credit_reg, credit_next;
    logic               credit_full;
    logic               acc;
    logic               take;
    logic               arrive;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               spare_valid_reg, spare_valid_next;
    logic [COUNT_W-1:0] spare_count_reg, spare_count_next;
    token_t             link [GRID_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_SIZE_RST;
            map_height_reg <= MAP_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_wdata;
                CFG_MAP_HEIGHT: map_height_reg <= cfg_wdata;
                default:        map_width_reg  <= map_width_reg;
            endcase
        end
    end

    assign used_w = (POS_W'(map_width_reg) > POS_W'(GRID_W))
                    ? POS_W'(GRID_W) : POS_W'(map_width_reg);
    assign used_h = (POS_W'(map_height_reg) > POS_W'(GRID_H))
                    ? POS_W'(GRID_H) : POS_W'(map_height_reg);

    mrcm_seq #(
        .GRID_H      (GRID_H),
        .REACH_LIMIT (REACH_LIMIT)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .col         (col),
        .row         (row),
        .min_reach   (min_reach),
        .max_reach   (max_reach),
        .used_w      (used_w),
        .used_h      (used_h),
        .credit_full (credit_full),
        .acc         (acc),
        .head        (link[0])
    );

    for (genvar x = 0; x < GRID_W; x++)
    begin : g_cell
        mrcm_cell #(
            .GRID_H (GRID_H),
            .CELL_X (x)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .used_w  (used_w),
            .tok_in  (link[x]),
            .tok_out (link[x+1])
        );
    end

    // results owed: accepted items whose result has not yet been transferred out
    assign credit_full = credit_reg == 2'd2;
    assign take        = out_valid_reg && !out_stall;
    assign arrive      = link[GRID_W].ret;

    always_comb
    begin
        credit_next      = credit_reg + 2'(acc) - 2'(take);
        out_valid_next   = out_valid_reg;
        out_count_next   = out_count_reg;
        spare_valid_next = spare_valid_reg;
        spare_count_next = spare_count_reg;
        if (take)
        begin
            out_valid_next   = spare_valid_reg;
            out_count_next   = spare_count_reg;
            spare_valid_next = 1'b0;
        end
        if (arrive)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_count_next = link[GRID_W].carry;
            end
            else
            begin
                spare_valid_next = 1'b1;
                spare_count_next = link[GRID_W].carry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg      <= '0;
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg      <= credit_next;
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg   <= out_count_next;
        spare_count_reg <= spare_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_count = out_count_reg;

endmodule

// ----- hdl/mrcm_checker.sv -----
// Port-level checks of the ring count map, bound to the top level.
module mrcm_checker
    import mrcm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [FUNC_W-1:0]  func,
    input logic               out_valid,
    input logic               out_stall,
    input logic [COUNT_W-1:0] cell_count
);

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // the grid clearing pass holds the input off right after reset
    a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("item taken during reset clearing pass");

    // adds and clears sweep rows, so the next cycle cannot take another item
    a_sweep_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (func == FN_ADD || func == FN_CLEAR) |=> in_stall)
        else $error("item taken during a row sweep");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_count))
        else $error("stalled result changed");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result withdrawn without transfer");

endmodule

bind manhattan_ring_count_map_unit mrcm_checker u_checker (.*);

// ----- dv/tb_manhattan_ring_count_map_unit.sv -----
// Self-checking bench for the Manhattan ring count map: grid tracker class, drivers and checks.
module tb_manhattan_ring_count_map_unit
    import mrcm_pkg::*;
();

    class ring_count_tracker;
        typedef struct {
            func_t              fn;
            int                 col;
            int                 row;
            logic [COUNT_W-1:0] count;
        } count_expect_t;

        logic [COUNT_W-1:0] grid [GRID_W_DEF*GRID_H_DEF];
        int unsigned        map_w;
        int unsigned        map_h;
        count_expect_t      owed [$];
        int                 faults;
        int                 n_add;
        int                 n_read;
        int                 n_clear;
        int                 n_other;
        int                 n_hits;
        int                 n_checked;

        function new();
            foreach (grid[i])
            begin
                grid[i] = '0;
            end
            map_w     = MAP_SIZE_RST;
            map_h     = MAP_SIZE_RST;
            faults    = 0;
            n_add     = 0;
            n_read    = 0;
            n_clear   = 0;
            n_other   = 0;
            n_hits    = 0;
            n_checked = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_MAP_WIDTH)
                map_w = val;
            else if (idx == CFG_MAP_HEIGHT)
                map_h = val;
        endfunction

        function int eff_w();
            return (map_w > GRID_W_DEF) ? GRID_W_DEF : int'(map_w);
        endfunction

        function int eff_h();
            return (map_h > GRID_H_DEF) ? GRID_H_DEF : int'(map_h);
        endfunction

        // Adds delta to every in-area cell within the given Manhattan distance.
        function void bump_diamond(int cx, int cy, int reach, logic [COUNT_W-1:0] delta);
            int w;
            int h;
            int dy;
            int lo;
            int hi;
            w = eff_w();
            h = eff_h();
            for (int y = 0; y < h; y++)
            begin
                dy = (y > cy) ? y - cy : cy - y;
                if (dy <= reach)
                begin
                    lo = cx - (reach - dy);
                    hi = cx + (reach - dy);
                    if (lo < 0)
                        lo = 0;
                    if (hi > w - 1)
                        hi = w - 1;
                    for (int x = lo; x <= hi; x++)
                        grid[y*GRID_W_DEF + x] = grid[y*GRID_W_DEF + x] + delta;
                end
            end
        endfunction

        function void note_item(func_t fn, int c, int r, int mn, int mx);
            count_expect_t e;
            int            lo_r;
            int            hi_r;
            e.fn    = fn;
            e.col   = c;
            e.row   = r;
            e.count = '0;
            lo_r    = (mn > REACH_LIMIT_DEF) ? REACH_LIMIT_DEF : mn;
            hi_r    = (mx > REACH_LIMIT_DEF) ? REACH_LIMIT_DEF : mx;
            case (fn)
                FN_ADD:
                begin
                    n_add++;
                    bump_diamond(c, r, hi_r, 8'd1);
                    if (lo_r >= 1)
                        bump_diamond(c, r, lo_r - 1, 8'hFF);
                end
                FN_READ:
                begin
                    n_read++;
                    if (c < eff_w() && r < eff_h())
                        e.count = grid[r*GRID_W_DEF + c];
                end
                FN_CLEAR:
                begin
                    n_clear++;
                    foreach (grid[i])
                    begin
                        grid[i] = '0;
                    end
                end
                default:
                    n_other++;
            endcase
            owed.push_back(e);
        endfunction

        function void check_count(logic [COUNT_W-1:0] got);
            count_expect_t e;
            n_checked++;
            if (owed.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("stray result: cell_count %0d with nothing outstanding", got);
                return;
            end
            e = owed.pop_front();
            if (got !== e.count)
            begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: %s at (%0d,%0d): expected cell_count %0d, got %0d",
                             e.fn.name(), e.col, e.row, e.count, got);
            end
            else if (e.fn == FN_READ && got != 0)
                n_hits++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_AW-1:0]  cfg_addr;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [REACH_W-1:0] min_reach;
    logic [REACH_W-1:0] max_reach;
    logic               out_valid;
    logic               out_stall;
    logic [COUNT_W-1:0] cell_count;

    int                 in_idle_pct;
    int                 out_idle_pct;
    int                 hot_col;
    int                 hot_row;
    bit                 retarget;
    ring_count_tracker  tracker;

    // phase sizes; the last entry is drawn at random
    int size_w [9] = '{127, 0, 1, 64, 1, 5, 0, 65, 0};
    int size_h [9] = '{127, 0, 1, 1, 64, 9, 40, 3, 0};

    manhattan_ring_count_map_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .col        (col),
        .row        (row),
        .min_reach  (min_reach),
        .max_reach  (max_reach),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_count (cell_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(4 * 600000);
        $display("FAILED: results differ");
        $finish;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_count(cell_count);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task put_item(func_t fn, int c, int r, int mn, int mx);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        func      = fn;
        col       = COORD_W'(c);
        row       = COORD_W'(r);
        min_reach = REACH_W'(mn);
        max_reach = REACH_W'(mx);
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_item(fn, c, r, mn, mx);
        @(negedge clk);
    endtask

    task drain_and_configure(int w, int h);
        in_valid = 1'b0;
        while (tracker.owed.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = CFG_MAP_WIDTH;
        cfg_wdata = CFG_W'(w);
        @(negedge clk);
        cfg_addr  = CFG_MAP_HEIGHT;
        cfg_wdata = CFG_W'(h);
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_reg(CFG_MAP_WIDTH, CFG_W'(w));
        tracker.set_reg(CFG_MAP_HEIGHT, CFG_W'(h));
    endtask

    // Adds cluster around a hot centre so that reads near it see real counts.
    task random_item();
        int    roll;
        int    c;
        int    r;
        int    mn;
        int    mx;
        int    w;
        int    h;
        func_t fn;
        w    = tracker.eff_w();
        h    = tracker.eff_h();
        roll = $urandom_range(0, 99);
        c    = $urandom_range(0, 63);
        r    = $urandom_range(0, 63);
        mn   = $urandom_range(0, 15);
        mx   = $urandom_range(0, 15);
        if (retarget || $urandom_range(0, 19) == 0)
        begin
            hot_col  = (w > 0) ? int'($urandom_range(0, w - 1)) : int'($urandom_range(0, 63));
            hot_row  = (h > 0) ? int'($urandom_range(0, h - 1)) : int'($urandom_range(0, 63));
            retarget = 1'b0;
        end
        if (roll < 50)
        begin
            fn = FN_ADD;
            if ($urandom_range(0, 1) == 1)
            begin
                c = hot_col;
                r = hot_row;
            end
            else if (w > 0 && h > 0 && $urandom_range(0, 4) != 0)
            begin
                c = $urandom_range(0, w - 1);
                r = $urandom_range(0, h - 1);
            end
            case ($urandom_range(0, 4))
                0:       mn = 0;
                1, 2:    mn = $urandom_range(0, mx);
                default: ;
            endcase
        end
        else if (roll < 92)
        begin
            fn = FN_READ;
            if ($urandom_range(0, 4) != 0)
            begin
                c = hot_col + int'($urandom_range(0, 12)) - 6;
                r = hot_row + int'($urandom_range(0, 12)) - 6;
                c = (c < 0) ? 0 : (c > 63) ? 63 : c;
                r = (r < 0) ? 0 : (r > 63) ? 63 : r;
            end
        end
        else if (roll < 96)
            fn = FN_CLEAR;
        else
            fn = FN_NONE;
        put_item(fn, c, r, mn, mx);
    endtask

    initial
    begin
        tracker      = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = CFG_MAP_WIDTH;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        func         = FN_ADD;
        col          = '0;
        row          = '0;
        min_reach    = '0;
        max_reach    = '0;
        out_stall    = 1'b0;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hot_col      = 0;
        hot_row      = 0;
        retarget     = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        drain_and_configure(64, 64);

        // corners, full reach, ring only, minimum above maximum (wraps below zero)
        put_item(FN_READ, 0, 0, 0, 0);
        put_item(FN_ADD, 0, 0, 0, 15);
        put_item(FN_READ, 0, 0, 15, 15);
        put_item(FN_READ, 15, 0, 0, 0);
        put_item(FN_ADD, 63, 63, 15, 15);
        put_item(FN_READ, 63, 48, 0, 0);
        put_item(FN_READ, 63, 63, 0, 0);
        put_item(FN_ADD, 32, 32, 10, 3);
        put_item(FN_READ, 32, 38, 0, 0);
        put_item(FN_READ, 32, 32, 0, 0);
        put_item(FN_ADD, 20, 20, 0, 0);
        put_item(FN_READ, 20, 20, 0, 0);
        put_item(FN_NONE, 63, 63, 15, 15);
        put_item(FN_READ, 63, 63, 0, 0);
        put_item(FN_ADD, 63, 0, 1, 15);
        put_item(FN_READ, 63, 0, 0, 0);
        put_item(FN_READ, 62, 0, 0, 0);
        put_item(FN_CLEAR, 0, 0, 0, 0);
        put_item(FN_READ, 32, 38, 0, 0);
        put_item(FN_READ, 62, 0, 0, 0);

        for (int phase = 0; phase < 18; phase++)
        begin
            in_idle_pct  = (phase < 6) ? 38 : (phase < 12) ? 60 : 0;
            out_idle_pct = (phase < 6) ? 60 : (phase < 12) ? 38 : 0;
            if (phase % 9 == 8)
                drain_and_configure($urandom_range(0, 127), $urandom_range(0, 127));
            else
                drain_and_configure(size_w[phase % 9], size_h[phase % 9]);
            retarget = 1'b1;
            repeat (100) random_item();
        end

        in_valid = 1'b0;
        while (tracker.owed.size() != 0)
            @(negedge clk);
        repeat (GRID_W_DEF + GRID_H_DEF) @(negedge clk);

        $display("Run covered %0d items: %0d adds, %0d reads (%0d non-zero), %0d clears, %0d idle codes.",
                 tracker.n_add + tracker.n_read + tracker.n_clear + tracker.n_other,
                 tracker.n_add, tracker.n_read, tracker.n_hits, tracker.n_clear, tracker.n_other);
        $display("Map sizes 0 to 127 on both axes, %0d results checked under three stall patterns.",
                 tracker.n_checked);
        if (tracker.faults == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
